[src/quadrature_tone_amplitude_core_assert.svh]
// Assertion macros for the quadrature tone amplitude block.
`ifndef QUADRATURE_TONE_AMPLITUDE_CORE_ASSERT_SVH
`define QUADRATURE_TONE_AMPLITUDE_CORE_ASSERT_SVH
`ifndef SYNTH
`define QTA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QTA_ASSERT_IMPLY(lbl, ante, cons)
`define QTA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/qta_pkg.sv]
// Shared types, constants and the sine table function of the tone amplitude block.
package qta_pkg;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int MAX_SAMPLES_DEF     = 16384;

  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 18;
  localparam int STEP_W   = 32;
  localparam int COUNT_W  = 15;
  localparam int N_W      = 17;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 96;
  localparam int RAD_W    = 132;
  localparam int ROOT_W   = 66;
  localparam int D_W      = 48;
  localparam int CNT_W    = 7;
  localparam int MUL_STEPS  = 48;
  localparam int ROOT_STEPS = 66;
  localparam int SCALE_SHIFT = 36;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] FULL_SCALE_PRODUCT = 32'd2147385345;
  localparam logic [AMP_W-1:0] AMP_MAX = 18'd131072;
  localparam logic [ROOT_W-1:0] Q_SAT = 66'd262143;
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 15'd10000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic REG_PHASE_STEP   = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  typedef struct packed {
    logic signed [SUM_W-1:0] i_sum;
    logic signed [SUM_W-1:0] q_sum;
    logic [N_W-1:0]          n;
  } qta_block_t;

  typedef struct packed {
    logic       valid;
    qta_block_t blk;
  } qta_push_t;

  typedef struct packed {
    logic       valid;
    logic       full;
    qta_block_t blk;
  } qta_queue_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SQRT,
    B_DIV,
    B_FIN,
    B_OUT
  } qta_back_state_t;

  function automatic logic [14:0] sine_entry(int k, int t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    longint v;
    x = (HALF_PI_Q30 * longint'(k)) >> t;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    term = ((term * x2) >> 30) / 6;   acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 20;  acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 42;  acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 72;  acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 110; acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 156; acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 210; acc = acc - longint'(term);
    if (acc < 0) acc = 0;
    v = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 32767) v = 32767;
    return 15'(v);
  endfunction
endpackage

[src/qta_channels.sv]
// Handshake channel interfaces for samples and amplitude results.
interface qta_sample_if import qta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface qta_amp_if import qta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AMP_W-1:0] amplitude;
  modport source (output valid, output amplitude, input ready);
  modport sink (input valid, input amplitude, output ready);
endinterface

[src/quadrature_tone_amplitude_core.sv]
// Top level of the quadrature tone amplitude meter.
//  channel   direction  payload             handshake
//  in_word   sink       sample[15:0]        valid/ready
//  out_word  source     amplitude[17:0]     valid/ready
//  cfg       write      cfg_index, cfg_data cfg_we
// One sample is taken per cycle unless a block's last sample waits on a full queue.
// The sine read is registered before the multiply-accumulate; the magnitude unit is serial.
// Two finished blocks wait in the queue; when it is full the last sample of a block stalls.
// A held result stalls the back end, then the input. Reset is synchronous, needs no sweep.
module quadrature_tone_amplitude_core import qta_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [STEP_W-1:0] cfg_data,
  qta_sample_if.sink        in_word,
  qta_amp_if.source         out_word
);
`include "quadrature_tone_amplitude_core_assert.svh"

  qta_push_t       push;
  qta_queue_stat_t qstat;
  logic            pop;

  qta_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .MAX_SAMPLES     (MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_word.valid),
    .in_ready   (in_word.ready),
    .in_sample  (in_word.sample),
    .queue_full (qstat.full),
    .push       (push)
  );

  qta_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (qstat)
  );

  qta_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_word.valid),
    .out_ready     (out_word.ready),
    .out_amplitude (out_word.amplitude)
  );

  `QTA_ASSERT_IMPLY(a_no_overflow, push.valid, !qstat.full)
  `QTA_ASSERT_IMPLY(a_pop_nonempty, pop, qstat.valid)
  `QTA_ASSERT_IMPLY(a_amp_range, out_word.valid, out_word.amplitude <= AMP_MAX)
  `QTA_ASSERT_NEXT(a_pop_starts_work, pop, !out_word.valid)
endmodule

[src/qta_front.sv]
// Front end: phase accumulator, sine table, per-sample multiply-accumulate and block framing.
module qta_front import qta_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [STEP_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                queue_full,
  output qta_push_t           push
);
  localparam int QTR = 1 << TABLE_ADDR_BITS;
  localparam int TA  = TABLE_ADDR_BITS;
  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_SAMPLES);

  logic [14:0] rom [QTR+1];
  for (genvar k = 0; k <= QTR; k++) begin : g_rom
    assign rom[k] = sine_entry(k, TABLE_ADDR_BITS);
  end

  logic [PHASE_BITS-1:0] step_r;
  logic [COUNT_W-1:0]    count_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [COUNT_W-1:0]    seen_r;

  logic                  s1_v_r;
  logic                  s1_last_r;
  logic [N_W-1:0]        s1_n_r;
  logic signed [16:0]    c_r;
  logic [14:0]           sin_m_r;
  logic [14:0]           cos_m_r;
  logic                  sin_neg_r;
  logic                  cos_neg_r;
  logic signed [SUM_W-1:0] i_sum_r;
  logic signed [SUM_W-1:0] q_sum_r;

  logic                  accept;
  logic                  advance;
  logic [1:0]            quad;
  logic [TA:0]           a0;
  logic [TA:0]           a1;
  logic [COUNT_W-1:0]    seen_inc;
  logic [N_W-1:0]        n_eff;
  logic                  last;
  logic signed [15:0]    sin_s;
  logic signed [15:0]    cos_s;
  logic signed [32:0]    prod_i;
  logic signed [32:0]    prod_q;
  logic signed [SUM_W-1:0] i_sum_nxt;
  logic signed [SUM_W-1:0] q_sum_nxt;

  assign advance  = s1_v_r && !(s1_last_r && queue_full);
  assign in_ready = !s1_v_r || advance;
  assign accept   = in_valid && in_ready;

  assign quad = phase_r[PHASE_BITS-1 -: 2];
  assign a0   = {1'b0, phase_r[PHASE_BITS-3 -: TA]};
  assign a1   = (TA+1)'(QTR) - a0;

  assign seen_inc = seen_r + COUNT_W'(1);
  always_comb begin
    if (count_r == '0) begin
      n_eff = N_W'(1);
    end else if ({{(N_W-COUNT_W){1'b0}}, count_r} > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = {{(N_W-COUNT_W){1'b0}}, count_r};
    end
  end
  assign last = {{(N_W-COUNT_W){1'b0}}, seen_inc} >= n_eff;

  assign sin_s  = sin_neg_r ? -$signed({1'b0, sin_m_r}) : $signed({1'b0, sin_m_r});
  assign cos_s  = cos_neg_r ? -$signed({1'b0, cos_m_r}) : $signed({1'b0, cos_m_r});
  assign prod_i = 33'(c_r) * 33'(cos_s);
  assign prod_q = 33'(c_r) * 33'(sin_s);
  assign i_sum_nxt = i_sum_r + SUM_W'(prod_i);
  assign q_sum_nxt = q_sum_r + SUM_W'(prod_q);

  assign push.valid     = s1_v_r && s1_last_r && !queue_full;
  assign push.blk.i_sum = i_sum_nxt;
  assign push.blk.q_sum = q_sum_nxt;
  assign push.blk.n     = s1_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      count_r   <= SAMPLE_COUNT_RESET;
      phase_r   <= '0;
      seen_r    <= '0;
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      i_sum_r   <= '0;
      q_sum_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PHASE_STEP) begin
          step_r <= cfg_data[PHASE_BITS-1:0];
        end else begin
          count_r <= cfg_data[COUNT_W-1:0];
        end
      end
      if (accept) begin
        phase_r   <= last ? '0 : phase_r + step_r;
        seen_r    <= last ? '0 : seen_inc;
        s1_v_r    <= 1'b1;
        s1_last_r <= last;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        i_sum_r <= s1_last_r ? '0 : i_sum_nxt;
        q_sum_r <= s1_last_r ? '0 : q_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_n_r    <= n_eff;
      c_r       <= {~in_sample[15], in_sample[14:0], 1'b1};
      sin_m_r   <= rom[quad[0] ? a1 : a0];
      cos_m_r   <= rom[quad[0] ? a0 : a1];
      sin_neg_r <= quad[1];
      cos_neg_r <= quad[1] ^ quad[0];
    end
  end
endmodule

[src/qta_queue.sv]
// Short queue of finished block sums between the front end and the magnitude unit.
module qta_queue import qta_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  qta_push_t       push,
  input  logic            pop,
  output qta_queue_stat_t stat
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qta_block_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_r;
  logic [PTR_W-1:0]       rd_r;
  logic [PTR_W:0]         fill_r;

  assign stat.valid = fill_r != '0;
  assign stat.full  = fill_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign stat.blk   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_r] <= push.blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push.valid) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push.valid && !pop) begin
        fill_r <= fill_r + (PTR_W+1)'(1);
      end else if (pop && !push.valid) begin
        fill_r <= fill_r - (PTR_W+1)'(1);
      end
    end
  end
endmodule

[src/qta_back.sv]
// Magnitude unit: serial squaring, digit-by-digit square root, division and rounding.
module qta_back import qta_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  qta_queue_stat_t qstat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [AMP_W-1:0] out_amplitude
);
  qta_back_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SQ_W-1:0]   mi_r;
  logic [SQ_W-1:0]   mq_r;
  logic [SUM_W-1:0]  bi_r;
  logic [SUM_W-1:0]  bq_r;
  logic [SQ_W-1:0]   s_r;
  logic [D_W-1:0]    d_r;
  logic [RAD_W-1:0]  t_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [D_W:0]      drem_r;
  logic [ROOT_W-1:0] quo_r;
  logic [AMP_W-1:0]  amp_r;

  logic              step_end;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic [D_W:0]      drem_sh;
  logic [ROOT_W-1:0] quo_inc;
  logic [SUM_W-1:0]  abs_i;
  logic [SUM_W-1:0]  abs_q;

  assign abs_i = qstat.blk.i_sum[SUM_W-1] ? SUM_W'(-qstat.blk.i_sum) : qstat.blk.i_sum;
  assign abs_q = qstat.blk.q_sum[SUM_W-1] ? SUM_W'(-qstat.blk.q_sum) : qstat.blk.q_sum;
  assign rem_sh  = {rem_r[ROOT_W-1:0], t_r[RAD_W-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign drem_sh = {drem_r[D_W-1:0], root_r[ROOT_W-1]};
  assign quo_inc = quo_r + ROOT_W'(1);

  always_comb begin
    unique case (state_r)
      B_MUL:   step_end = cnt_r == CNT_W'(MUL_STEPS-1);
      B_SQRT:  step_end = cnt_r == CNT_W'(ROOT_STEPS-1);
      B_DIV:   step_end = cnt_r == CNT_W'(ROOT_STEPS-1);
      default: step_end = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (qstat.valid) state_nxt = B_MUL;
      B_MUL:   if (step_end) state_nxt = B_SQRT;
      B_SQRT:  if (step_end) state_nxt = B_DIV;
      B_DIV:   if (step_end) state_nxt = B_FIN;
      B_FIN:   state_nxt = B_OUT;
      B_OUT:   if (out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop           = (state_r == B_IDLE) && qstat.valid;
    out_valid     = state_r == B_OUT;
    out_amplitude = amp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (step_end || state_r == B_IDLE) ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        mi_r <= SQ_W'(abs_i);
        mq_r <= SQ_W'(abs_q);
        bi_r <= abs_i;
        bq_r <= abs_q;
        s_r  <= '0;
        d_r  <= D_W'(qstat.blk.n) * D_W'(FULL_SCALE_PRODUCT);
      end
      B_MUL: begin
        s_r  <= s_r + (bi_r[0] ? mi_r : '0) + (bq_r[0] ? mq_r : '0);
        mi_r <= mi_r << 1;
        mq_r <= mq_r << 1;
        bi_r <= bi_r >> 1;
        bq_r <= bq_r >> 1;
        if (step_end) begin
          t_r    <= {s_r + (bi_r[0] ? mi_r : '0) + (bq_r[0] ? mq_r : '0),
                     SCALE_SHIFT'(0)};
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      B_SQRT: begin
        t_r <= t_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        if (step_end) begin
          drem_r <= '0;
        end
      end
      B_DIV: begin
        root_r <= root_r << 1;
        if (drem_sh >= {1'b0, d_r}) begin
          drem_r <= drem_sh - {1'b0, d_r};
          quo_r  <= {quo_r[ROOT_W-2:0], 1'b1};
        end else begin
          drem_r <= drem_sh;
          quo_r  <= {quo_r[ROOT_W-2:0], 1'b0};
        end
      end
      B_FIN: begin
        amp_r <= (quo_r >= Q_SAT) ? AMP_MAX : quo_inc[AMP_W:1];
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end
endmodule
